/* design/wifi_ie_security_parser_unit_assert.svh */
// ----------------------------------------------------------------------------
// wifi_ie_security_parser_unit_assert.svh
// Assertion macros used by the checker of the parser unit.
// ----------------------------------------------------------------------------
`ifndef WIFI_IE_SECURITY_PARSER_UNIT_ASSERT_SVH
`define WIFI_IE_SECURITY_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define WIESP_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define WIESP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

// Next-cycle implication that is checked in reset as well.
`define WIESP_ASSERT_NEXT_ALWAYS(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("assertion failed");

`endif

/* design/wiesp_pkg.sv */
// ----------------------------------------------------------------------------
// wiesp_pkg
// Types, codes and suite lookup functions of the RSN / WPA element parser.
// ----------------------------------------------------------------------------
package wiesp_pkg;

    localparam logic [7:0]  EID_RSN    = 8'd48;
    localparam logic [7:0]  EID_VENDOR = 8'd221;
    localparam logic [31:0] WPA_OUI_TYPE = 32'h0050F201;
    localparam logic [31:0] VERSION_ONE  = 32'h00000100;

    typedef enum logic [1:0] {
        HDR_TYPE = 2'd0,
        HDR_LEN  = 2'd1,
        HDR_BODY = 2'd2
    } hdr_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_OUI     = 3'd1,
        PH_VERSION = 3'd2,
        PH_GROUP   = 3'd3,
        PH_PCOUNT  = 3'd4,
        PH_PSUITE  = 3'd5,
        PH_ACOUNT  = 3'd6,
        PH_ASUITE  = 3'd7
    } ph_t;

    typedef struct packed {
        logic [2:0] key_mgmt;
        logic [3:0] pairwise_ciphers;
        logic [2:0] group_cipher;
        logic [1:0] protocols;
    } sec_result_t;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] ie_byte;
    } ie_beat_t;

    function automatic logic [2:0] map_group(input logic [31:0] v, input logic rsn);
        logic [2:0] r;
        r = 3'd1;
        if (rsn) begin
            case (v)
                32'h000FAC01: r = 3'd3;
                32'h000FAC02: r = 3'd4;
                32'h000FAC04: r = 3'd5;
                32'h000FAC05: r = 3'd6;
                default:      r = 3'd1;
            endcase
        end else begin
            case (v)
                32'h0050F200: r = 3'd2;
                32'h0050F201: r = 3'd3;
                32'h0050F202: r = 3'd4;
                32'h0050F204: r = 3'd5;
                32'h0050F205: r = 3'd6;
                default:      r = 3'd1;
            endcase
        end
        return r;
    endfunction

    function automatic logic [3:0] map_pairwise(input logic [31:0] v, input logic rsn);
        logic [3:0] r;
        r = 4'd0;
        if (rsn) begin
            case (v)
                32'h000FAC00: r = 4'd2;
                32'h000FAC02: r = 4'd4;
                32'h000FAC04: r = 4'd8;
                default:      r = 4'd0;
            endcase
        end else begin
            case (v)
                32'h0050F200: r = 4'd1;
                32'h0050F202: r = 4'd4;
                32'h0050F204: r = 4'd8;
                default:      r = 4'd0;
            endcase
        end
        return r;
    endfunction

    function automatic logic [2:0] map_akm(input logic [31:0] v, input logic rsn);
        logic [2:0] r;
        r = 3'd0;
        if (rsn) begin
            case (v)
                32'h000FAC01, 32'h000FAC03, 32'h000FAC05: r = 3'd2;
                32'h000FAC02, 32'h000FAC04, 32'h000FAC06: r = 3'd4;
                default: r = 3'd0;
            endcase
        end else begin
            case (v)
                32'h0050F200: r = 3'd1;
                32'h0050F201: r = 3'd2;
                32'h0050F202: r = 3'd4;
                default:      r = 3'd0;
            endcase
        end
        return r;
    endfunction

endpackage

/* design/wiesp_queue.sv */
// ----------------------------------------------------------------------------
// wiesp_queue
// Front end: accepts byte beats and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module wiesp_queue import wiesp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  ie_beat_t in_beat,
    output logic     out_valid,
    input  logic     out_pop,
    output ie_beat_t out_beat
);

    ie_beat_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_beat  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_beat;
        end
    end

endmodule

/* design/wiesp_parser.sv */
// ----------------------------------------------------------------------------
// wiesp_parser
// Back end: a byte a cycle unless a last byte waits; registers result.
// ----------------------------------------------------------------------------
module wiesp_parser import wiesp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_pop,
    input  ie_beat_t    in_beat,
    output logic        res_valid,
    input  logic        res_ready,
    output sec_result_t res_data
);

    hdr_t        hdr_reg, hdr_next;
    ph_t         ph_reg, ph_next;
    logic [7:0]  etype_reg, etype_next;
    logic [7:0]  elen_reg, elen_next;
    logic [7:0]  eoff_reg, eoff_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  fpos_reg, fpos_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        abort_reg, abort_next;
    sec_result_t comm_reg, comm_next;
    sec_result_t shad_reg, shad_next;
    logic        out_valid_reg;
    sec_result_t out_data_reg;

    logic        take;
    logic [7:0]  b;
    logic [31:0] v;
    logic [15:0] c;
    logic [2:0]  fpos_v;
    logic [2:0]  need;
    logic        rsn;
    logic [8:0]  off9, len9;
    logic        a_ok, p_ok, g_ok, v_ok, c_fit;
    logic [5:0]  cnt_dec;

    // Only a last byte has to wait for the output register to free up.
    assign take      = in_valid && (!in_beat.last_byte || !out_valid_reg || res_ready);
    assign in_pop    = take;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;
    assign b         = in_beat.ie_byte;

    always_comb begin
        hdr_next   = hdr_reg;
        ph_next    = ph_reg;
        etype_next = etype_reg;
        elen_next  = elen_reg;
        eoff_next  = eoff_reg;
        shift_next = shift_reg;
        fpos_next  = fpos_reg;
        cnt_next   = cnt_reg;
        abort_next = abort_reg;
        comm_next  = comm_reg;
        shad_next  = shad_reg;

        rsn     = (etype_reg == EID_RSN);
        v       = {shift_reg[23:0], b};
        c       = {v[7:0], v[15:8]};
        fpos_v  = fpos_reg + 3'd1;
        need    = (ph_reg == PH_VERSION || ph_reg == PH_PCOUNT || ph_reg == PH_ACOUNT)
                  ? 3'd2 : 3'd4;
        off9    = {1'b0, eoff_reg} + 9'd1;
        len9    = {1'b0, elen_reg};
        a_ok    = (off9 + 9'd2) < len9;
        p_ok    = (off9 + 9'd2) <= len9;
        v_ok    = p_ok;
        g_ok    = (off9 + 9'd4) <= len9;
        c_fit   = ({c, 2'b00} + {9'd0, off9}) <= {9'd0, len9};
        cnt_dec = cnt_reg - 6'd1;

        if (take) begin
            unique case (hdr_reg)
                HDR_LEN: begin
                    elen_next  = b;
                    eoff_next  = 8'd0;
                    abort_next = 1'b0;
                    shad_next  = comm_reg;
                    ph_next    = PH_IDLE;
                    fpos_next  = 3'd0;
                    shift_next = 32'd0;
                    if (etype_reg == EID_RSN) begin
                        shad_next.protocols        = comm_reg.protocols | 2'b10;
                        shad_next.group_cipher     = 3'd5;
                        shad_next.pairwise_ciphers = 4'd8;
                        shad_next.key_mgmt         = 3'd2;
                        if (b < 8'd2) abort_next = 1'b1;
                        else ph_next = PH_VERSION;
                    end else if (etype_reg == EID_VENDOR) begin
                        if (b < 8'd4) abort_next = 1'b1;
                        else ph_next = PH_OUI;
                    end else begin
                        abort_next = 1'b1;
                    end
                    if (b == 8'd0) begin
                        comm_next = shad_next;
                        hdr_next  = HDR_TYPE;
                    end else begin
                        hdr_next  = HDR_BODY;
                    end
                end
                HDR_BODY: begin
                    eoff_next = off9[7:0];
                    if (!abort_reg) begin
                        shift_next = v;
                        fpos_next  = fpos_v;
                        if (fpos_v >= need) begin
                            fpos_next  = 3'd0;
                            shift_next = 32'd0;
                            case (ph_reg)
                                PH_OUI: begin
                                    if (v != WPA_OUI_TYPE) begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end else begin
                                        shad_next.protocols = shad_reg.protocols | 2'b01;
                                        if (shad_reg.protocols[1]) begin
                                            ph_next = PH_IDLE; abort_next = 1'b1;
                                        end else begin
                                            shad_next.group_cipher     = 3'd4;
                                            shad_next.pairwise_ciphers = 4'd4;
                                            shad_next.key_mgmt         = 3'd2;
                                            if (!v_ok) begin
                                                ph_next = PH_IDLE; abort_next = 1'b1;
                                            end else begin
                                                ph_next = PH_VERSION;
                                            end
                                        end
                                    end
                                end
                                PH_VERSION: begin
                                    if (v != VERSION_ONE) begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end else if (g_ok) begin
                                        ph_next = PH_GROUP;
                                    end else if (p_ok) begin
                                        shad_next.pairwise_ciphers = 4'd0;
                                        ph_next = PH_PCOUNT;
                                    end else begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end
                                end
                                PH_GROUP: begin
                                    shad_next.group_cipher = map_group(v, rsn);
                                    if (p_ok) begin
                                        shad_next.pairwise_ciphers = 4'd0;
                                        ph_next = PH_PCOUNT;
                                    end else begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end
                                end
                                PH_PCOUNT: begin
                                    if (!c_fit) begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end else begin
                                        cnt_next = c[5:0];
                                        if (c != 16'd0) begin
                                            ph_next = PH_PSUITE;
                                        end else if (a_ok) begin
                                            shad_next.key_mgmt = 3'd0;
                                            ph_next = PH_ACOUNT;
                                        end else begin
                                            ph_next = PH_IDLE; abort_next = 1'b1;
                                        end
                                    end
                                end
                                PH_PSUITE: begin
                                    shad_next.pairwise_ciphers =
                                        shad_reg.pairwise_ciphers | map_pairwise(v, rsn);
                                    cnt_next = cnt_dec;
                                    if (cnt_dec == 6'd0) begin
                                        if (a_ok) begin
                                            shad_next.key_mgmt = 3'd0;
                                            ph_next = PH_ACOUNT;
                                        end else begin
                                            ph_next = PH_IDLE; abort_next = 1'b1;
                                        end
                                    end
                                end
                                PH_ACOUNT: begin
                                    if (!c_fit || c == 16'd0) begin
                                        if (c_fit) cnt_next = c[5:0];
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end else begin
                                        cnt_next = c[5:0];
                                        ph_next  = PH_ASUITE;
                                    end
                                end
                                PH_ASUITE: begin
                                    shad_next.key_mgmt = shad_reg.key_mgmt | map_akm(v, rsn);
                                    cnt_next = cnt_dec;
                                    if (cnt_dec == 6'd0) begin
                                        ph_next = PH_IDLE; abort_next = 1'b1;
                                    end
                                end
                                default: begin
                                    ph_next = PH_IDLE; abort_next = 1'b1;
                                end
                            endcase
                        end
                    end
                    if (off9 >= len9) begin
                        comm_next = shad_next;
                        hdr_next  = HDR_TYPE;
                    end
                end
                default: begin
                    etype_next = b;
                    hdr_next   = HDR_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_beat.last_byte)) begin
            hdr_reg   <= HDR_TYPE;
            ph_reg    <= PH_IDLE;
            etype_reg <= 8'd0;
            elen_reg  <= 8'd0;
            eoff_reg  <= 8'd0;
            shift_reg <= 32'd0;
            fpos_reg  <= 3'd0;
            cnt_reg   <= 6'd0;
            abort_reg <= 1'b0;
            comm_reg  <= '0;
            shad_reg  <= '0;
        end else begin
            hdr_reg   <= hdr_next;
            ph_reg    <= ph_next;
            etype_reg <= etype_next;
            elen_reg  <= elen_next;
            eoff_reg  <= eoff_next;
            shift_reg <= shift_next;
            fpos_reg  <= fpos_next;
            cnt_reg   <= cnt_next;
            abort_reg <= abort_next;
            comm_reg  <= comm_next;
            shad_reg  <= shad_next;
        end
    end

    // Hold the result until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && in_beat.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (res_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && in_beat.last_byte) begin
            out_data_reg <= comm_next;
        end
    end

endmodule

/* design/wifi_ie_security_parser_unit.sv */
// A buffer's last byte passes through a queue slot and then the result register on its way to m_tdata.
// Throughput: one byte per cycle while no last byte waits on the result register, set by the single-byte parser step.
// Keeps taking bytes while a finished result waits; only the next last byte waits.
// Reset: synchronous active-low aresetn empties the queue, drops any result
// and returns the parser to expecting an element type byte.
// ----------------------------------------------------------------------------
// wifi_ie_security_parser_unit
// RSN / WPA information element parser with byte queue and result register.
// ----------------------------------------------------------------------------
module wifi_ie_security_parser_unit import wiesp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ie_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] protocols, [4:2] group_cipher,
                                   // [8:5] pairwise_ciphers, [11:9] key_mgmt, [15:12] zero
);

    ie_beat_t    in_beat, q_beat;
    logic        q_valid, q_pop;
    sec_result_t res;

    assign in_beat.ie_byte   = s_tdata;
    assign in_beat.last_byte = s_tlast;

    wiesp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_beat  (q_beat)
    );

    wiesp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_pop    (q_pop),
        .in_beat   (q_beat),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (res)
    );

    assign m_tdata = {4'd0, res};

endmodule

/* design/wiesp_checker.sv */
// ----------------------------------------------------------------------------
// wiesp_checker
// Port-level checks of the parser unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "wifi_ie_security_parser_unit_assert.svh"

module wiesp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `WIESP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `WIESP_ASSERT_NOW(a_group_code, aclk, aresetn, m_tvalid, m_tdata[4:2] != 3'd7)
    `WIESP_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[15:12] == 4'd0)
    `WIESP_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)

endmodule

bind wifi_ie_security_parser_unit wiesp_checker u_wiesp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RSN / WPA element parser: streams element
// buffers byte by byte, predicts each buffer's security summary and compares.
// ----------------------------------------------------------------------------
module tb;
    import wiesp_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    wifi_ie_security_parser_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #6;
        aclk = 1'b1; #6;
    end

    // ---------------- predictor state ----------------
    hdr_t        hdr_st;
    ph_t         phase;
    logic [7:0]  eid;
    logic [7:0]  elen;
    logic [7:0]  eoff;
    logic [31:0] shreg;
    logic [15:0] suites_left;
    logic        abort_elem;
    logic [2:0]  fpos;
    sec_result_t committed, shadow;

    sec_result_t summary_q[$];
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned idle_cycles;
    logic        receiver_stall_on;

    function automatic void clear_parser();
        hdr_st = HDR_TYPE; phase = PH_IDLE; eid = '0; elen = '0; eoff = '0;
        shreg = '0; suites_left = '0; abort_elem = 1'b0; fpos = '0;
        committed = '0; shadow = '0;
    endfunction

    function automatic void halt_decode();
        phase = PH_IDLE;
        abort_elem = 1'b1;
    endfunction

    function automatic void goto_phase(ph_t p);
        phase = p; fpos = '0; shreg = '0;
    endfunction

    function automatic void open_akm_count();
        if (32'(eoff) + 2 < 32'(elen)) begin
            shadow.key_mgmt = '0;
            goto_phase(PH_ACOUNT);
        end else halt_decode();
    endfunction

    function automatic void open_pairwise_count();
        if (32'(eoff) + 2 <= 32'(elen)) begin
            shadow.pairwise_ciphers = '0;
            goto_phase(PH_PCOUNT);
        end else halt_decode();
    endfunction

    function automatic logic [2:0] group_code(logic [31:0] v, logic rsn);
        if (rsn) begin
            case (v)
                32'h000FAC01: return 3'd3;
                32'h000FAC02: return 3'd4;
                32'h000FAC04: return 3'd5;
                32'h000FAC05: return 3'd6;
                default:      return 3'd1;
            endcase
        end
        case (v)
            32'h0050F200: return 3'd2;
            32'h0050F201: return 3'd3;
            32'h0050F202: return 3'd4;
            32'h0050F204: return 3'd5;
            32'h0050F205: return 3'd6;
            default:      return 3'd1;
        endcase
    endfunction

    function automatic logic [3:0] pairwise_bit(logic [31:0] v, logic rsn);
        if (rsn) begin
            case (v)
                32'h000FAC00: return 4'd2;
                32'h000FAC02: return 4'd4;
                32'h000FAC04: return 4'd8;
                default:      return 4'd0;
            endcase
        end
        case (v)
            32'h0050F200: return 4'd1;
            32'h0050F202: return 4'd4;
            32'h0050F204: return 4'd8;
            default:      return 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] akm_bit(logic [31:0] v, logic rsn);
        if (rsn) begin
            case (v)
                32'h000FAC01, 32'h000FAC03, 32'h000FAC05: return 3'd2;
                32'h000FAC02, 32'h000FAC04, 32'h000FAC06: return 3'd4;
                default: return 3'd0;
            endcase
        end
        case (v)
            32'h0050F200: return 3'd1;
            32'h0050F201: return 3'd2;
            32'h0050F202: return 3'd4;
            default:      return 3'd0;
        endcase
    endfunction

    function automatic void load_count(logic [31:0] c, ph_t suite_ph, logic is_akm);
        if (c * 4 + 32'(eoff) > 32'(elen)) begin
            halt_decode();
            return;
        end
        suites_left = c[15:0];
        if (c == 0) begin
            if (is_akm) halt_decode(); else open_akm_count();
        end else goto_phase(suite_ph);
    endfunction

    function automatic void decode_word();
        logic [2:0]  need;
        logic        rsn;
        logic [31:0] v;
        logic [31:0] c;
        need = (phase == PH_VERSION || phase == PH_PCOUNT || phase == PH_ACOUNT) ? 3'd2 : 3'd4;
        rsn = (eid == EID_RSN);
        if (fpos < need) return;
        v = shreg;
        fpos = '0;
        shreg = '0;
        c = {16'd0, v[7:0], v[15:8]};
        case (phase)
            PH_OUI: begin
                if (v != WPA_OUI_TYPE) halt_decode();
                else begin
                    shadow.protocols[0] = 1'b1;
                    if (shadow.protocols[1]) halt_decode();
                    else begin
                        shadow.group_cipher = 3'd4;
                        shadow.pairwise_ciphers = 4'd4;
                        shadow.key_mgmt = 3'd2;
                        if (32'(eoff) + 2 > 32'(elen)) halt_decode();
                        else goto_phase(PH_VERSION);
                    end
                end
            end
            PH_VERSION: begin
                if (v != VERSION_ONE) halt_decode();
                else if (32'(eoff) + 4 <= 32'(elen)) goto_phase(PH_GROUP);
                else open_pairwise_count();
            end
            PH_GROUP: begin
                shadow.group_cipher = group_code(v, rsn);
                open_pairwise_count();
            end
            PH_PCOUNT: load_count(c, PH_PSUITE, 1'b0);
            PH_PSUITE: begin
                shadow.pairwise_ciphers |= pairwise_bit(v, rsn);
                suites_left = suites_left - 16'd1;
                if (suites_left == 0) open_akm_count();
            end
            PH_ACOUNT: load_count(c, PH_ASUITE, 1'b1);
            PH_ASUITE: begin
                shadow.key_mgmt |= akm_bit(v, rsn);
                suites_left = suites_left - 16'd1;
                if (suites_left == 0) halt_decode();
            end
            default: halt_decode();
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        if (hdr_st == HDR_LEN) begin
            elen = b; eoff = '0; abort_elem = 1'b0;
            shadow = committed;
            goto_phase(PH_IDLE);
            if (eid == EID_RSN) begin
                shadow.protocols[1] = 1'b1;
                shadow.group_cipher = 3'd5;
                shadow.pairwise_ciphers = 4'd8;
                shadow.key_mgmt = 3'd2;
                if (elen < 2) halt_decode(); else goto_phase(PH_VERSION);
            end else if (eid == EID_VENDOR) begin
                if (elen < 4) halt_decode(); else goto_phase(PH_OUI);
            end else halt_decode();
            if (elen == 0) begin
                committed = shadow;
                hdr_st = HDR_TYPE;
            end else hdr_st = HDR_BODY;
        end else if (hdr_st == HDR_BODY) begin
            eoff = eoff + 8'd1;
            if (!abort_elem) begin
                shreg = {shreg[23:0], b};
                fpos = fpos + 3'd1;
                decode_word();
            end
            if (eoff >= elen) begin
                committed = shadow;
                hdr_st = HDR_TYPE;
            end
        end else begin
            eid = b;
            hdr_st = HDR_LEN;
        end
        if (last) begin
            summary_q = {summary_q, committed};
            clear_parser();
        end
    endfunction

    // ---------------- driver ----------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    logic gaps_on;

    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned g;
        g = gaps_on ? pick_gap() : 0;
        // Drop valid only for a real gap; back-to-back beats keep it high.
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        parse_byte(b, last);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_buffer(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (summary_q.size() != 0) @(negedge aclk);
    endtask

    // ---------------- element builders ----------------
    function automatic logic [31:0] rand_suite(logic rsn);
        logic [31:0] base;
        base = rsn ? 32'h000FAC00 : 32'h0050F200;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return base | 32'($urandom_range(7, 255));
            default: return base | 32'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic void put_word(ref logic [7:0] q[$], input logic [31:0] w);
        q = {q, w[31:24], w[23:16], w[15:8], w[7:0]};
    endfunction

    // Build a security element; occasionally corrupt its OUI, version or counts.
    function automatic void build_sec(ref logic [7:0] q[$], input logic rsn);
        logic [7:0] body[$];
        int unsigned np, na, trunc;
        np = $urandom_range(0, 3);
        na = $urandom_range(0, 3);
        if (!rsn) put_word(body, ($urandom_range(0, 15) == 0) ? $urandom() : WPA_OUI_TYPE);
        if ($urandom_range(0, 15) == 0) begin
            body = {body, 8'($urandom()), 8'($urandom())};
        end else begin
            body = {body, 8'h01, 8'h00};
        end
        put_word(body, rand_suite(rsn));
        body = {body, ($urandom_range(0, 15) == 0) ? 8'($urandom()) : np[7:0]};
        body = {body, ($urandom_range(0, 20) == 0) ? 8'($urandom()) : 8'h00};
        repeat (np) put_word(body, rand_suite(rsn));
        body = {body, ($urandom_range(0, 15) == 0) ? 8'($urandom()) : na[7:0]};
        body = {body, 8'h00};
        repeat (na) put_word(body, rand_suite(rsn));
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            body = {body, 8'($urandom())};
        // Shorten the body at a random point now and then.
        if ($urandom_range(0, 4) == 0) begin
            trunc = $urandom_range(0, body.size());
            while (body.size() > trunc) void'(body.pop_back());
        end
        q = {q, rsn ? EID_RSN : EID_VENDOR, 8'(body.size())};
        foreach (body[i]) q = {q, body[i]};
    endfunction

    function automatic void build_other(ref logic [7:0] q[$]);
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        q = {q, 8'($urandom_range(0, 255)), 8'(n)};
        repeat (n) q = {q, 8'($urandom())};
    endfunction

    // ---------------- checker ----------------
    always @(posedge aclk) begin
        sec_result_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[11:0];
            if (summary_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", m_tdata);
            end else begin
                exp = summary_q.pop_front();
                if (got.protocols !== exp.protocols || got.group_cipher !== exp.group_cipher
                        || got.pairwise_ciphers !== exp.pairwise_ciphers
                        || got.key_mgmt !== exp.key_mgmt || m_tdata[15:12] !== 4'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp proto %0d grp %0d pair %h akm %h, got %h",
                                 exp.protocols, exp.group_cipher, exp.pairwise_ciphers,
                                 exp.key_mgmt, m_tdata);
                end
            end
        end
    end

    // Receiver stalls
    int unsigned ready_hold;
    always @(negedge aclk) begin
        if (!receiver_stall_on) m_tready <= 1'b1;
        else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= ~m_tready;
            ready_hold <= m_tready ? pick_gap() : $urandom_range(0, 6);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        logic [7:0] q[$];
        // Empty RSN element still marks RSN and its defaults
        q = '{EID_RSN, 8'd0}; send_buffer(q);
        // Full RSN: tkip group, ccmp + none pairwise, akm count larger than the one psk suite given
        q = '{EID_RSN, 8'd22, 8'h01, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h02,
              8'h02, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h04, 8'h00, 8'h0F, 8'hAC, 8'h00,
              8'h02, 8'h00, 8'h00, 8'h0F, 8'hAC, 8'h02};
        send_buffer(q);
        // WPA vendor element followed by RSN; then RSN followed by WPA
        q = '{EID_VENDOR, 8'd6, 8'h00, 8'h50, 8'hF2, 8'h01, 8'h01, 8'h00,
              EID_RSN, 8'd2, 8'h01, 8'h00};
        send_buffer(q);
        q = '{EID_RSN, 8'd2, 8'h01, 8'h00, EID_VENDOR, 8'd8, 8'h00, 8'h50, 8'hF2, 8'h01,
              8'h01, 8'h00, 8'h00, 8'h50};
        send_buffer(q);
        // Bad version, unknown group suite, truncated element, lone type byte
        q = '{EID_RSN, 8'd4, 8'hFF, 8'hFF, 8'h00, 8'h00}; send_buffer(q);
        q = '{EID_RSN, 8'd6, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00}; send_buffer(q);
        q = '{EID_RSN, 8'd255, 8'h01}; send_buffer(q);
        q = '{8'hFF}; send_buffer(q);
    endtask

    task automatic test_random_buffers();
        logic [7:0] q[$];
        int unsigned nel;
        while (beats_sent < 750) begin
            q.delete();
            nel = $urandom_range(1, 3);
            repeat (nel) begin
                case ($urandom_range(0, 5))
                    0, 1:    build_sec(q, 1'b1);
                    2, 3:    build_sec(q, 1'b0);
                    default: build_other(q);
                endcase
            end
            if ($urandom_range(0, 7) == 0) void'(q.pop_back());
            send_buffer(q);
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
    endtask

    initial begin
        mismatches = 0; beats_sent = 0; ready_hold = 0;
        receiver_stall_on = 1'b0; gaps_on = 1'b0;
        clear_parser();
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0; m_tready = 1'b1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        wait_drained();
        gaps_on = 1'b1;
        receiver_stall_on = 1'b1;
        test_random_buffers();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && summary_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
